// ===== rtl/core/swcs_pkg.sv =====
// ----------------------------------------------------------------------------
// swcs_pkg
// Shared types and constants of the sliding window confidence stop unit.
// ----------------------------------------------------------------------------
`default_nettype none

package swcs_pkg;

	// Field widths of the transfer payloads and registers
	localparam int SAMPLE_BITS = 24;
	localparam int FILL_W      = 12;
	localparam int COUNT_W     = 32;
	localparam int WLEN_W      = 12;
	localparam int THR_W       = 23;
	localparam int CFG_ADDR_W  = 2;
	localparam int CFG_DATA_W  = 23;

	localparam int DEF_MAX_WINDOW = 2048;

	// Register indexes
	localparam logic [CFG_ADDR_W-1:0] REG_ENABLE    = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_WINDOW    = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_THRESHOLD = 2'd2;

	// Register reset values
	localparam logic [WLEN_W-1:0] WLEN_RESET = 12'd8;
	localparam logic [THR_W-1:0]  THR_RESET  = 23'd52429;

	// Threshold limits, Q7.16
	localparam logic [THR_W-1:0] THR_LOW  = 23'd6554;
	localparam logic [THR_W-1:0] THR_HIGH = 23'd6553600;

	// Item kinds
	localparam logic KIND_SAMPLE = 1'b0;
	localparam logic KIND_CLEAR  = 1'b1;

	localparam logic [SAMPLE_BITS-1:0] MEAN_ONES = '1;
	localparam logic [COUNT_W-1:0]     COUNT_MAX = '1;

	typedef struct packed {
		logic                   kind;
		logic [SAMPLE_BITS-1:0] confidence;
	} in_item_t;

	typedef struct packed {
		logic                   continue_flag;
		logic [SAMPLE_BITS-1:0] group_mean;
		logic [SAMPLE_BITS-1:0] least_group_mean;
		logic                   window_full;
		logic [FILL_W-1:0]      fill_count;
		logic [COUNT_W-1:0]     token_count;
		logic                   stop_latched;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVICT,
		ST_WRITE,
		ST_DIV_LOAD,
		ST_DIV,
		ST_UPDATE,
		ST_RESULT
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic start;
		logic clear;
		logic evict;
		logic write;
		logic div_start;
		logic update;
		logic load_out;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic full;
		logic div_done;
	} status_t;

endpackage

`default_nettype wire

// ===== rtl/core/swcs_ram.sv =====
// ----------------------------------------------------------------------------
// swcs_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module swcs_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 2048
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

`default_nettype wire

// ===== rtl/core/swcs_div.sv =====
// ----------------------------------------------------------------------------
// swcs_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module swcs_div #(
	parameter int DVD_W = 36,
	parameter int DVS_W = 12
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [DVD_W-1:0] dividend,
	input  wire logic [DVS_W-1:0] divisor,
	output logic      [DVD_W-1:0] quotient,
	output logic                  done
);

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVD_W-1:0] dq_q;
	logic [DVS_W:0]   trial;
	logic [DVS_W:0]   diff;
	logic             ge;

	assign trial = {rem_q, dq_q[DVD_W-1]};
	assign diff  = trial - {1'b0, divisor};
	assign ge    = (trial >= {1'b0, divisor});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNT_W'(DVD_W);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - 1'b1;
			done_q <= (cnt_q == CNT_W'(1));
		end
	end

	// Dividend shifts out at the top while quotient bits shift in at the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dq_q  <= dividend;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
			dq_q  <= {dq_q[DVD_W-2:0], ge};
		end
	end

	assign quotient = dq_q;
	assign done     = done_q;

endmodule

`default_nettype wire

// ===== rtl/core/swcs_ctrl.sv =====
// ----------------------------------------------------------------------------
// swcs_ctrl
// Sequencer for one item: evict if full, write, divide, update, output result.
// ----------------------------------------------------------------------------
`default_nettype none

module swcs_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              enable,
	input  wire logic              in_valid,
	input  wire logic              in_kind,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	input  wire swcs_pkg::status_t status,
	output swcs_pkg::cmd_t         cmd
);

	import swcs_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.start = 1'b1;
					if (!enable) begin
						state_d = ST_RESULT;
					end else if (in_kind == KIND_CLEAR) begin
						cmd.clear = 1'b1;
						state_d   = ST_RESULT;
					end else if (status.full) begin
						state_d = ST_EVICT;
					end else begin
						state_d = ST_WRITE;
					end
				end
			end
			ST_EVICT: begin
				cmd.evict = 1'b1;
				state_d   = ST_WRITE;
			end
			ST_WRITE: begin
				cmd.write = 1'b1;
				state_d   = ST_DIV_LOAD;
			end
			ST_DIV_LOAD: begin
				cmd.div_start = 1'b1;
				state_d       = ST_DIV;
			end
			ST_DIV: begin
				if (status.div_done) begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				cmd.update = 1'b1;
				state_d    = ST_RESULT;
			end
			ST_RESULT: begin
				// wait for the output register to drain
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// ===== rtl/core/swcs_dp.sv =====
// ----------------------------------------------------------------------------
// swcs_dp
// Window store, running sum, counters, mean divider and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module swcs_dp #(
	parameter int MAX_WINDOW = swcs_pkg::DEF_MAX_WINDOW
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire swcs_pkg::cmd_t                cmd,
	output swcs_pkg::status_t                  status,
	input  wire logic                          cfg_clear,
	input  wire logic [swcs_pkg::FILL_W-1:0]   win_len,
	input  wire logic [swcs_pkg::THR_W-1:0]    threshold,
	input  wire swcs_pkg::in_item_t            in_data,
	output swcs_pkg::out_item_t                out_data
);

	import swcs_pkg::*;

	localparam int PTR_W = $clog2(MAX_WINDOW);
	localparam int SUM_W = SAMPLE_BITS + $clog2(MAX_WINDOW + 1);
	localparam int IDX_W = FILL_W + 1;

	logic [PTR_W-1:0]       ptr_q;
	logic [FILL_W-1:0]      held_q;
	logic [SUM_W-1:0]       sum_q;
	logic [SAMPLE_BITS-1:0] lowest_q;
	logic [SAMPLE_BITS-1:0] latest_q;
	logic                   stop_q;
	logic [COUNT_W-1:0]     count_q;
	logic [SAMPLE_BITS-1:0] sample_q;
	logic                   cont_q;
	out_item_t              out_q;

	logic [SAMPLE_BITS-1:0] old_sample;
	logic [SUM_W-1:0]       quotient;
	logic                   div_done;
	logic [SAMPLE_BITS-1:0] mean;
	logic [IDX_W-1:0]       idx_sum;
	logic [PTR_W-1:0]       wr_idx;
	logic [PTR_W-1:0]       ptr_next;
	logic                   full;
	logic                   do_clear;

	assign full     = (held_q >= win_len);
	assign do_clear = cmd.clear || cfg_clear;
	assign mean     = quotient[SAMPLE_BITS-1:0];

	// Ring position of the new sample: oldest plus fill count, wrapped
	always_comb begin
		idx_sum = IDX_W'(ptr_q) + IDX_W'(held_q);
		if (idx_sum >= IDX_W'(MAX_WINDOW)) begin
			idx_sum = idx_sum - IDX_W'(MAX_WINDOW);
		end
		wr_idx = idx_sum[PTR_W-1:0];
	end

	assign ptr_next = (ptr_q == PTR_W'(MAX_WINDOW - 1)) ? '0 : ptr_q + 1'b1;

	swcs_ram #(
		.WIDTH (SAMPLE_BITS),
		.DEPTH (MAX_WINDOW)
	) u_store (
		.clk     (clk),
		.wr_en   (cmd.write),
		.wr_addr (wr_idx),
		.wr_data (sample_q),
		.rd_addr (ptr_q),
		.rd_data (old_sample)
	);

	swcs_div #(
		.DVD_W (SUM_W),
		.DVS_W (FILL_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (sum_q),
		.divisor  (held_q),
		.quotient (quotient),
		.done     (div_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q    <= '0;
			held_q   <= '0;
			sum_q    <= '0;
			lowest_q <= MEAN_ONES;
			latest_q <= '0;
			stop_q   <= 1'b0;
			count_q  <= '0;
		end else if (do_clear) begin
			ptr_q    <= '0;
			held_q   <= '0;
			sum_q    <= '0;
			lowest_q <= MEAN_ONES;
			latest_q <= '0;
			stop_q   <= 1'b0;
			count_q  <= '0;
		end else begin
			if (cmd.evict) begin
				// drop the oldest sample from the window
				sum_q  <= sum_q - SUM_W'(old_sample);
				ptr_q  <= ptr_next;
				held_q <= held_q - 1'b1;
			end
			if (cmd.write) begin
				sum_q  <= sum_q + SUM_W'(sample_q);
				held_q <= held_q + 1'b1;
				if (count_q != COUNT_MAX) begin
					count_q <= count_q + 1'b1;
				end
			end
			if (cmd.update) begin
				latest_q <= mean;
				if (full) begin
					if (mean < lowest_q) begin
						lowest_q <= mean;
					end
					if (mean < SAMPLE_BITS'(threshold)) begin
						stop_q <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			sample_q <= in_data.confidence;
			cont_q   <= 1'b1;
		end else if (cmd.update && full && (mean < SAMPLE_BITS'(threshold))) begin
			cont_q <= 1'b0;
		end
		if (cmd.load_out) begin
			out_q.continue_flag    <= cont_q;
			out_q.group_mean       <= latest_q;
			out_q.least_group_mean <= lowest_q;
			out_q.window_full      <= full;
			out_q.fill_count       <= held_q;
			out_q.token_count      <= count_q;
			out_q.stop_latched     <= stop_q;
		end
	end

	assign status.full     = full;
	assign status.div_done = div_done;
	assign out_data        = out_q;

endmodule

`default_nettype wire

// ===== rtl/core/sliding_window_confidence_stop_unit.sv =====
// ----------------------------------------------------------------------------
// sliding_window_confidence_stop_unit
// Sliding window mean of token confidences with a latched stop decision.
// ----------------------------------------------------------------------------
// A confidence sample takes an eviction step once the window is full, and
// skips it while the window is still filling; it is then written to the
// window store, the mean is divided out and the mean and stop state updated.
// The window sum is SUM_W = 24 + clog2(MAX_WINDOW + 1) bits wide, 36 bits at
// the default MAX_WINDOW of 2048; the bit-serial divider that forms the
// window mean works one quotient bit per cycle. The window store is written
// once per sample and read once per eviction, through its single ports. A
// clear item, and every item while enable is low, goes from its transfer
// straight to the result step. The next transfer in is taken the cycle after
// the result register loads, and a stalled result holds the input off. The
// window store needs no initialization after reset: only entries already
// written are ever evicted. Write the registers only while no item is in
// flight; a write to window_length clears the window as a clear item does.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_confidence_stop_unit #(
	parameter int MAX_WINDOW = swcs_pkg::DEF_MAX_WINDOW
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              wr_en,
	input  wire logic [swcs_pkg::CFG_ADDR_W-1:0]   wr_index,
	input  wire logic [swcs_pkg::CFG_DATA_W-1:0]   wr_data,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire swcs_pkg::in_item_t                in_data,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output swcs_pkg::out_item_t                    out_data
);

	import swcs_pkg::*;

	logic              enable_q;
	logic [WLEN_W-1:0] win_len_q;
	logic [THR_W-1:0]  thr_q;
	logic [FILL_W-1:0] win_eff;
	logic [THR_W-1:0]  thr_eff;
	logic              cfg_clear;
	cmd_t              cmd;
	status_t           status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q  <= 1'b0;
			win_len_q <= WLEN_RESET;
			thr_q     <= THR_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_ENABLE:    enable_q  <= wr_data[0];
				REG_WINDOW:    win_len_q <= wr_data[WLEN_W-1:0];
				REG_THRESHOLD: thr_q     <= wr_data[THR_W-1:0];
				default:       ;
			endcase
		end
	end

	assign cfg_clear = wr_en && (wr_index == REG_WINDOW);

	// Clamp window length to 1..MAX_WINDOW and threshold to its legal range
	always_comb begin
		if (win_len_q == '0) begin
			win_eff = FILL_W'(1);
		end else if ((FILL_W + 1)'(win_len_q) > (FILL_W + 1)'(MAX_WINDOW)) begin
			win_eff = FILL_W'(MAX_WINDOW);
		end else begin
			win_eff = FILL_W'(win_len_q);
		end
		if (thr_q < THR_LOW) begin
			thr_eff = THR_LOW;
		end else if (thr_q > THR_HIGH) begin
			thr_eff = THR_HIGH;
		end else begin
			thr_eff = thr_q;
		end
	end

	swcs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.enable    (enable_q),
		.in_valid  (in_valid),
		.in_kind   (in_data.kind),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	swcs_dp #(
		.MAX_WINDOW (MAX_WINDOW)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.cfg_clear (cfg_clear),
		.win_len   (win_eff),
		.threshold (thr_eff),
		.in_data   (in_data),
		.out_data  (out_data)
	);

	// Each transfer in starts a multi-cycle sequence
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input taken again right after a transfer");

	a_fill_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.fill_count <= win_eff))
		else $error("fill count exceeds window length");

	a_stop_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.continue_flag) |-> out_data.stop_latched)
		else $error("continue dropped without stop latched");

	a_full_means_filled: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.window_full) |-> out_data.continue_flag)
		else $error("stop reported on a partial window");

endmodule

`default_nettype wire
